[rtl/patr_pkg.sv]
// ----------------------------------------------------------------------------
// patr_pkg
// Shared widths, constants and controller/datapath types of the peak
// alternation pitch tracker.
// ----------------------------------------------------------------------------
package patr_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int FRAC_W     = 8;
    localparam int AVG_W      = 24;
    localparam int FREQ_W     = 25;
    localparam int SMOOTH_W   = 16;
    localparam int RATE_W     = 18;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;
    // rate shifted by 16 plus half the average can carry into one more bit
    localparam int DIV_NUM_W  = RATE_W + 17;
    localparam int DIV_DEN_W  = AVG_W;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;

    localparam int SIM_NUM = 100;
    localparam int SIM_DEN = 3;

    localparam logic [SMOOTH_W-1:0] SMOOTHING_RST   = 16'd32768;
    localparam logic [AVG_W-1:0]    MIN_PERIOD_RST  = 24'd5120;
    localparam logic [AVG_W-1:0]    MAX_PERIOD_RST  = 24'd614400;
    localparam logic [RATE_W-1:0]   SAMPLE_RATE_RST = 18'd48000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTHING,
        CFG_MIN_PERIOD,
        CFG_MAX_PERIOD,
        CFG_SAMPLE_RATE
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_TAKE,
        OP_DIFF,
        OP_SIMC,
        OP_HOLD,
        OP_SUM,
        OP_HALF,
        OP_MUL,
        OP_ADJ,
        OP_LIMIT,
        OP_FREQ
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load;
    } t_dp_cmd;

    typedef struct packed {
        logic evt;
        logic avg_zero;
        logic sim;
        logic held_zero;
        logic div_done;
    } t_dp_stat;

endpackage

[rtl/patr_div.sv]
// ----------------------------------------------------------------------------
// patr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module patr_div
    import patr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_NUM_W - 1);

    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   w_trial;
    logic [DIV_DEN_W+1:0] w_diff;
    logic                 w_fit;

    assign w_trial = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};
    assign w_fit   = ~w_diff[DIV_DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator bits shift out the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");

endmodule

[rtl/patr_dp.sv]
// ----------------------------------------------------------------------------
// patr_dp
// Datapath: peak flag tracking, period compare, smoothing and frequency.
// ----------------------------------------------------------------------------
module patr_dp
    import patr_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_pos,
    input  logic                 i_neg,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic [FREQ_W-1:0]    o_freq,
    output logic [AVG_W-1:0]     o_avg
);

    localparam int PER_W  = COUNT_BITS + FRAC_W;
    localparam int CAND_W = ((PER_W > AVG_W) ? PER_W : AVG_W) + 1;
    localparam int CMP_W  = CAND_W + 8;
    localparam int PROD_W = CAND_W + SMOOTH_W;

    localparam logic [CMP_W-1:0]  K_NUM     = CMP_W'(SIM_NUM);
    localparam logic [CMP_W-1:0]  K_DEN     = CMP_W'(SIM_DEN);
    localparam logic [PROD_W-1:0] ROUND_HLF = PROD_W'(1) << (SMOOTH_W - 1);
    localparam logic [AVG_W-1:0]  AVG_MAX   = '1;

    logic [SMOOTH_W-1:0]   r_smooth;
    logic [AVG_W-1:0]      r_min;
    logic [AVG_W-1:0]      r_max;
    logic [RATE_W-1:0]     r_rate;

    logic                  r_armed;
    logic                  r_prev_pos;
    logic                  r_prev_neg;
    logic [COUNT_BITS-1:0] r_count;
    logic [AVG_W-1:0]      r_held;
    logic [AVG_W-1:0]      r_avg;
    logic [FREQ_W-1:0]     r_freq;

    logic                  r_evt;
    logic [CAND_W-1:0]     r_cand;
    logic [CAND_W-1:0]     r_dist;
    logic [CAND_W:0]       r_tot;
    logic                  r_up;
    logic                  r_sim;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_ok;
    logic [FREQ_W-1:0]     r_out_freq;
    logic [AVG_W-1:0]      r_out_avg;

    logic                  w_evt;
    logic [PER_W-1:0]      w_per;
    logic [CAND_W-1:0]     w_avg_ext;
    logic [PROD_W-1:0]     w_rnd;
    logic [CAND_W-1:0]     w_step;
    logic [CAND_W:0]       w_sum;
    logic [AVG_W-1:0]      w_new_avg;
    logic [DIV_NUM_W-1:0]  w_num;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [DIV_NUM_W-1:0]  w_quot;

    assign w_evt     = r_armed & i_neg & ~r_prev_neg;
    assign w_per     = {r_count, {FRAC_W{1'b0}}};
    assign w_avg_ext = CAND_W'(r_avg);

    assign w_rnd  = r_prod + ROUND_HLF;
    assign w_step = w_rnd[PROD_W-1:SMOOTH_W];
    assign w_sum  = (CAND_W+1)'(r_avg) + (CAND_W+1)'(w_step);

    always_comb begin
        if (r_avg == '0) begin
            w_new_avg = (r_cand > CAND_W'(AVG_MAX)) ? AVG_MAX : r_cand[AVG_W-1:0];
        end else if (r_up) begin
            w_new_avg = (w_sum > (CAND_W+1)'(AVG_MAX)) ? AVG_MAX : w_sum[AVG_W-1:0];
        end else begin
            w_new_avg = (w_step >= w_avg_ext) ? '0 : (r_avg - w_step[AVG_W-1:0]);
        end
    end

    assign w_num       = DIV_NUM_W'({r_rate, 16'd0}) + DIV_NUM_W'(r_avg >> 1);
    assign w_div_start = (i_cmd.op == OP_LIMIT);

    patr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_avg),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= SMOOTHING_RST;
            r_min    <= MIN_PERIOD_RST;
            r_max    <= MAX_PERIOD_RST;
            r_rate   <= SAMPLE_RATE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SMOOTHING:   r_smooth <= i_cfg_wdata[SMOOTH_W-1:0];
                CFG_MIN_PERIOD:  r_min    <= i_cfg_wdata[AVG_W-1:0];
                CFG_MAX_PERIOD:  r_max    <= i_cfg_wdata[AVG_W-1:0];
                CFG_SAMPLE_RATE: r_rate   <= i_cfg_wdata[RATE_W-1:0];
            endcase
        end
    end

    // tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_prev_pos <= 1'b0;
            r_prev_neg <= 1'b0;
            r_count    <= '0;
            r_held     <= '0;
            r_avg      <= '0;
            r_freq     <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_TAKE: begin
                    if (r_armed) begin
                        if (w_evt) begin
                            r_armed <= 1'b0;
                        end
                    end else if (i_pos && !r_prev_pos) begin
                        r_armed <= 1'b1;
                    end
                    r_prev_pos <= i_pos;
                    r_prev_neg <= i_neg;
                    // a closed period restarts the count, then the sample counts
                    if (w_evt) begin
                        r_count <= COUNT_BITS'(1);
                    end else if (r_count != '1) begin
                        r_count <= r_count + COUNT_BITS'(1);
                    end
                end
                OP_HOLD: r_held <= r_cand[AVG_W-1:0];
                OP_ADJ: begin
                    r_avg  <= w_new_avg;
                    r_held <= '0;
                end
                OP_FREQ: begin
                    if (!r_ok) begin
                        r_freq <= '0;
                    end else if (|w_quot[DIV_NUM_W-1:FREQ_W]) begin
                        r_freq <= '1;
                    end else begin
                        r_freq <= w_quot[FREQ_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_TAKE: begin
                r_evt  <= w_evt;
                r_cand <= CAND_W'(w_per);
            end
            OP_DIFF: begin
                r_up   <= (r_cand >= w_avg_ext);
                r_dist <= (r_cand >= w_avg_ext) ? (r_cand - w_avg_ext) : (w_avg_ext - r_cand);
                r_tot  <= (CAND_W+1)'(r_cand) + (CAND_W+1)'(w_avg_ext);
            end
            OP_SIMC:  r_sim  <= (CMP_W'(r_dist) * K_NUM) < (CMP_W'(r_tot) * K_DEN);
            OP_SUM:   r_cand <= r_cand + CAND_W'(r_held);
            OP_HALF:  r_cand <= r_cand >> 1;
            OP_MUL:   r_prod <= PROD_W'(r_dist) * PROD_W'(r_smooth);
            OP_LIMIT: r_ok   <= (r_avg != '0) && (r_avg <= r_max) && (r_avg >= r_min)
                                && (r_rate != '0);
            default: ;
        endcase
        if (i_cmd.load) begin
            r_out_freq <= r_freq;
            r_out_avg  <= r_avg;
        end
    end

    assign o_stat.evt       = r_evt;
    assign o_stat.avg_zero  = (r_avg == '0);
    assign o_stat.sim       = r_sim;
    assign o_stat.held_zero = (r_held == '0);
    assign o_stat.div_done  = w_div_done;

    assign o_freq = r_out_freq;
    assign o_avg  = r_out_avg;

    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_TAKE && w_evt) |=> (r_count == COUNT_BITS'(1)))
        else $error("count not restarted after period event");

    a_fold_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_ADJ) |=> (r_held == '0))
        else $error("held period survives a fold");

endmodule

[rtl/patr_ctrl.sv]
// ----------------------------------------------------------------------------
// patr_ctrl
// Sequencer: handshakes and the step order of one period event.
// ----------------------------------------------------------------------------
module patr_ctrl
    import patr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_DIFF,
        ST_SIMC,
        ST_DEC,
        ST_HALF,
        ST_MUL,
        ST_ADJ,
        ST_LIMIT,
        ST_DIV,
        ST_FREQ,
        ST_WRITE
    } t_state;

    t_state r_state;
    logic   r_pass;
    logic   r_halved;
    logic   r_out_valid;

    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_s_tvalid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        o_cmd.op   = OP_IDLE;
        o_cmd.load = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_cmd.op = w_accept ? OP_TAKE : OP_IDLE;
            ST_DIFF:  o_cmd.op = OP_DIFF;
            ST_SIMC:  o_cmd.op = OP_SIMC;
            ST_DEC: begin
                if (!r_pass && !i_stat.avg_zero && !i_stat.sim) begin
                    o_cmd.op = i_stat.held_zero ? OP_HOLD : OP_SUM;
                end
            end
            ST_HALF:  o_cmd.op = OP_HALF;
            ST_MUL:   o_cmd.op = OP_MUL;
            ST_ADJ:   o_cmd.op = OP_ADJ;
            ST_LIMIT: o_cmd.op = OP_LIMIT;
            ST_FREQ:  o_cmd.op = OP_FREQ;
            ST_WRITE: o_cmd.load = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pass      <= 1'b0;
            r_halved    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_pass   <= 1'b0;
                        r_halved <= 1'b0;
                        r_state  <= ST_CHK;
                    end
                end
                ST_CHK:  r_state <= i_stat.evt ? ST_DIFF : ST_WRITE;
                ST_DIFF: r_state <= r_halved ? ST_MUL : ST_SIMC;
                ST_SIMC: r_state <= ST_DEC;
                ST_DEC: begin
                    if (!r_pass) begin
                        if (i_stat.avg_zero || i_stat.sim) begin
                            r_state <= ST_MUL;
                        end else if (i_stat.held_zero) begin
                            r_state <= ST_WRITE;
                        end else begin
                            // second look with the held and the new period summed
                            r_pass  <= 1'b1;
                            r_state <= ST_DIFF;
                        end
                    end else begin
                        r_state <= i_stat.sim ? ST_MUL : ST_HALF;
                    end
                end
                ST_HALF: begin
                    r_halved <= 1'b1;
                    r_state  <= ST_DIFF;
                end
                ST_MUL:   r_state <= ST_ADJ;
                ST_ADJ:   r_state <= ST_LIMIT;
                ST_LIMIT: r_state <= ST_DIV;
                ST_DIV:   r_state <= i_stat.div_done ? ST_FREQ : ST_DIV;
                ST_FREQ:  r_state <= ST_WRITE;
                ST_WRITE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    a_write_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && r_out_valid && !i_m_tready) |=> (r_state == ST_WRITE))
        else $error("result written over a pending word");

    a_accept_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_CHK))
        else $error("accepted word not processed");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_out_valid)
        else $error("result loaded without valid");

endmodule

[rtl/peak_alternation_pitch_tracker_core.sv]
// ----------------------------------------------------------------------------
// peak_alternation_pitch_tracker_core
// Pitch tracker from alternating positive and negative peak flags.
// ----------------------------------------------------------------------------
// steps: a word that closes no period goes straight to the result write; a
//   held period skips the update; an average update runs the divider first
// throughput: the input is taken only by an idle sequencer, so a new word
//   waits until the last is written; the bit-serial divider dominates
// reset: synchronous active-low, clears tracking state and output valid and
//   restores register defaults; no clearing pass
module peak_alternation_pitch_tracker_core
    import patr_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // pos_peak, neg_peak
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // frequency, average_period
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic [FREQ_W-1:0] w_freq;
    logic [AVG_W-1:0]  w_avg;

    patr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    patr_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pos       (i_s_axis_tdata[0]),
        .i_neg       (i_s_axis_tdata[1]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_freq      (w_freq),
        .o_avg       (w_avg)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W - FREQ_W - AVG_W){1'b0}}, w_avg, w_freq};

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stream-level testbench for the peak alternation pitch tracker core. Peak
// flag words go in with random gaps, results come out under random stalls,
// and each result is compared with an in-bench model of the period tracker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import patr_pkg::*;

    localparam int          RANDOM_ITEMS  = 100;
    localparam int          LONG_LEN      = 520;
    localparam int          SETTLE_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int          MAX_PRINTS    = 40;
    localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;
    localparam longint unsigned AVG_MAX  = (64'd1 << AVG_W) - 1;
    localparam longint unsigned FREQ_MAX = (64'd1 << FREQ_W) - 1;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [AVG_W-1:0]  avg;
    } pitch_t;

    logic                   i_clk     = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    t_cfg_idx               cfg_idx   = CFG_SMOOTHING;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    // model of the tracker
    logic [SMOOTH_W-1:0]       cfg_smooth;
    logic [AVG_W-1:0]          cfg_min;
    logic [AVG_W-1:0]          cfg_max;
    logic [RATE_W-1:0]         cfg_rate;
    logic                      trk_armed;
    logic                      trk_prev_pos;
    logic                      trk_prev_neg;
    logic [COUNT_BITS_DEF-1:0] trk_count;
    logic [AVG_W-1:0]          trk_held;
    logic [AVG_W-1:0]          trk_avg;
    logic [FREQ_W-1:0]         trk_freq;

    pitch_t      pitch_q[$];
    int          err_count     = 0;
    int          tx_count      = 0;
    int unsigned cycle_cnt     = 0;
    bit          tx_idle_en    = 1'b1;
    bit          rx_idle_en    = 1'b1;
    int          rx_hold_cycles = 0;

    peak_alternation_pitch_tracker_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // pos_peak, neg_peak
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // frequency, average_period
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
    endtask

    function automatic bit periods_similar(input longint unsigned a, input longint unsigned b);
        longint unsigned d;
        d = (a > b) ? (a - b) : (b - a);
        return d * SIM_NUM < (a + b) * SIM_DEN;
    endfunction

    task automatic reset_tracker();
        cfg_smooth   = SMOOTHING_RST;
        cfg_min      = MIN_PERIOD_RST;
        cfg_max      = MAX_PERIOD_RST;
        cfg_rate     = SAMPLE_RATE_RST;
        trk_armed    = 1'b0;
        trk_prev_pos = 1'b0;
        trk_prev_neg = 1'b0;
        trk_count    = '0;
        trk_held     = '0;
        trk_avg      = '0;
        trk_freq     = '0;
    endtask

    task automatic apply_register(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        case (idx)
            CFG_SMOOTHING:   cfg_smooth = val[SMOOTH_W-1:0];
            CFG_MIN_PERIOD:  cfg_min    = val[AVG_W-1:0];
            CFG_MAX_PERIOD:  cfg_max    = val[AVG_W-1:0];
            CFG_SAMPLE_RATE: cfg_rate   = val[RATE_W-1:0];
            default: ;
        endcase
    endtask

    // exponential smoothing of the average, then the frequency division
    task automatic fold_into_average(input longint unsigned per);
        longint unsigned avg;
        longint unsigned dec;
        longint unsigned num;
        longint unsigned f;
        avg = 64'(trk_avg);
        if (avg == 0) begin
            avg = per;
        end else if (per >= avg) begin
            avg = avg + (((per - avg) * 64'(cfg_smooth) + 64'd32768) >> 16);
        end else begin
            dec = ((avg - per) * 64'(cfg_smooth) + 64'd32768) >> 16;
            avg = (dec >= avg) ? 64'd0 : (avg - dec);
        end
        if (avg > AVG_MAX)
            avg = AVG_MAX;
        trk_avg = avg[AVG_W-1:0];
        if (avg == 0 || avg > 64'(cfg_max) || avg < 64'(cfg_min) || cfg_rate == 0) begin
            trk_freq = '0;
        end else begin
            num = 64'(cfg_rate);
            num = (num << 16) + (avg >> 1);
            f = num / avg;
            trk_freq = (f > FREQ_MAX) ? FREQ_MAX[FREQ_W-1:0] : f[FREQ_W-1:0];
        end
        trk_held = '0;
    endtask

    task automatic measure_period();
        longint unsigned per;
        longint unsigned sum;
        per = 64'(trk_count);
        per = per << FRAC_W;
        if (trk_avg == 0 || periods_similar(per, 64'(trk_avg))) begin
            fold_into_average(per);
        end else if (trk_held == 0) begin
            trk_held = per[AVG_W-1:0];
        end else begin
            sum = per + 64'(trk_held);
            // a split period: use the sum whole if it matches, else half of it
            if (periods_similar(sum, 64'(trk_avg)))
                fold_into_average(sum);
            else
                fold_into_average(sum >> 1);
        end
        trk_count = '0;
    endtask

    task automatic track_sample(input logic pos, input logic neg);
        if (trk_armed) begin
            if (neg && !trk_prev_neg) begin
                trk_armed = 1'b0;
                measure_period();
            end
        end else if (pos && !trk_prev_pos) begin
            trk_armed = 1'b1;
        end
        trk_prev_pos = pos;
        trk_prev_neg = neg;
        if (trk_count != COUNT_MAX)
            trk_count++;
        pitch_q.push_back('{freq: trk_freq, avg: trk_avg});
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
        pitch_t want;
        if (pitch_q.size() == 0) begin
            report_mismatch("result word with none pending", 0, 64'(word));
        end else begin
            want = pitch_q.pop_front();
            if (word[FREQ_W-1:0] != want.freq)
                report_mismatch("frequency", 64'(want.freq), 64'(word[FREQ_W-1:0]));
            if (word[FREQ_W +: AVG_W] != want.avg)
                report_mismatch("average_period", 64'(want.avg),
                                64'(word[FREQ_W +: AVG_W]));
        end
    endtask

    // one process sees every handshake, so model order follows the bus
    always @(posedge i_clk) begin
        if (!rst_n) begin
            reset_tracker();
        end else begin
            if (cfg_we)
                apply_register(cfg_idx, cfg_wdata);
            if (s_tvalid && s_tready)
                track_sample(s_tdata[0], s_tdata[1]);
            if (m_tvalid && m_tready)
                check_result(m_tdata);
        end
    end

    initial begin : rx_side
        int stall;
        @(posedge rst_n);
        forever begin
            if (rx_hold_cycles > 0) begin
                repeat (rx_hold_cycles) begin
                    @(negedge i_clk);
                    m_tready <= 1'b0;
                end
                rx_hold_cycles = 0;
            end
            stall = rx_idle_en ? $urandom_range(0, 18) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                m_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid)
                @(posedge i_clk);
        end
    end

    task automatic send_sample(input logic pos, input logic neg);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 18) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-2){1'b0}}, neg, pos};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        tx_count++;
    endtask

    // arm, wander, close: len words from one period event to the next
    task automatic send_cycle(input int len);
        send_sample(1'b1, 1'b0);
        repeat (len - 2)
            send_sample(1'($urandom_range(0, 1)), 1'b0);
        send_sample(1'b0, 1'b1);
    endtask

    task automatic wait_pitch_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pitch_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [CFG_W-1:0] smooth, input logic [CFG_W-1:0] min_p,
                             input logic [CFG_W-1:0] max_p, input logic [CFG_W-1:0] rate);
        wait_pitch_drained();
        write_register(CFG_SMOOTHING, smooth);
        write_register(CFG_MIN_PERIOD, min_p);
        write_register(CFG_MAX_PERIOD, max_p);
        write_register(CFG_SAMPLE_RATE, rate);
    endtask

    task automatic test_reset_defaults();
        // arm on the first word, close on the second: shortest period
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b1);
        repeat (3)
            send_cycle(8);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
    endtask

    task automatic test_register_extremes();
        // no limits, widest rate: tiny averages give frequencies near full scale
        write_all(24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'hFFFFFF);
        send_cycle(2);
        send_cycle(2);
        // zero weight freezes the average
        write_all(24'd0, 24'd0, 24'hFFFFFF, 24'd192000);
        send_cycle(2);
        send_cycle(3);
        // crossed limits
        write_all(24'd32768, 24'hFFFFFF, 24'd0, 24'd48000);
        send_cycle(2);
        send_cycle(2);
        // zero sample rate
        write_all(24'd32768, 24'd0, 24'hFFFFFF, 24'd0);
        send_cycle(2);
        write_all(24'd1, 24'd1, 24'd1, 24'd1);
        send_cycle(2);
    endtask

    task automatic test_held_periods();
        write_all(24'd65535, 24'd256, 24'hFFFFFF, 24'd44100);
        send_cycle(20);
        send_cycle(20);
        // split period whose sum matches
        send_cycle(10);
        send_cycle(10);
        // pair whose sum does not match, halved
        send_cycle(4);
        send_cycle(4);
    endtask

    task automatic test_long_period();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        // widest rate over a period long enough that half the average is wide
        write_all(24'd32768, 24'd0, 24'hFFFFFF, 24'hFFFFFF);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b0);
        repeat (LONG_LEN)
            send_sample(1'($urandom_range(0, 1)), 1'b0);
        send_sample(1'b0, 1'b1);
    endtask

    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_all(24'd40000, 24'd512, 24'hFFFFFF, 24'd96000);
        rx_hold_cycles = 400;
        repeat (4)
            send_cycle(6);
        wait_pitch_drained();
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
    endtask

    task automatic randomize_registers();
        logic [CFG_W-1:0] smooth, min_p, max_p, rate;
        case ($urandom_range(0, 3))
            0:       smooth = '0;
            1:       smooth = '1;
            default: smooth = CFG_W'($urandom);
        endcase
        min_p = ($urandom_range(0, 5) == 0) ? CFG_W'($urandom)
                                            : CFG_W'($urandom_range(0, 20 * 256));
        max_p = ($urandom_range(0, 7) == 0) ? CFG_W'(0)
                                            : CFG_W'($urandom_range(40 * 256, 24'hFFFFFF));
        case ($urandom_range(0, 7))
            0:       rate = '0;
            1:       rate = CFG_W'($urandom);
            default: rate = CFG_W'($urandom_range(1, 192000));
        endcase
        write_all(smooth, min_p, max_p, rate);
    endtask

    task automatic test_random_streams();
        int start;
        int phase_end;
        int base;
        int kind;
        int len;
        start = tx_count;
        while (tx_count - start < RANDOM_ITEMS) begin
            randomize_registers();
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            base = $urandom_range(2, 40);
            phase_end = tx_count + $urandom_range(60, 160);
            while (tx_count < phase_end) begin
                kind = $urandom_range(0, 9);
                if (kind <= 5) begin
                    len = base + $urandom_range(0, 2) - 1;
                    send_cycle((len < 2) ? 2 : len);
                end else if (kind <= 7) begin
                    len = (base + 1) / 2;
                    send_cycle((len < 2) ? 2 : len);
                    send_cycle((len < 2) ? 2 : len);
                end else if (kind == 8) begin
                    send_cycle($urandom_range(2, 80));
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial begin
        repeat (10)
            @(negedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_register_extremes();
        test_held_periods();
        test_long_period();
        test_output_backpressure();
        test_random_streams();
        wait_pitch_drained();
        if (pitch_q.size() != 0)
            report_mismatch("results still pending", 0, 64'(pitch_q.size()));
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
